/* design/ipfw_pkg.sv */
// ----------------------------------------------------------------------------
// ipfw_pkg
// shared types and constants for the ipv6 masked-rule firewall cell chain
// ----------------------------------------------------------------------------
package ipfw_pkg;

	// number of rule slots, one cell per slot (1 to 256)
	localparam int NUM_RULES = 8;

	localparam int ADDR_W  = 64;
	localparam int PRIO_W  = 8;
	localparam int INDEX_W = 8;
	localparam int FLAGS_W = 3;

	// flag bit positions inside a rule
	localparam int FLG_SRC_BIT  = 0;
	localparam int FLG_DST_BIT  = 1;
	localparam int FLG_DROP_BIT = 2;

	// stream widths
	localparam int IN_DATA_W  = 408;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;

	typedef enum logic [1:0] {
		MODE_LOOKUP   = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_DEL_ADDR = 2'd2,
		MODE_DEL_IDX  = 2'd3
	} mode_t;

	// one request as it travels down the chain
	typedef struct packed {
		mode_t               mode;
		logic [ADDR_W-1:0]   first_hi;
		logic [ADDR_W-1:0]   first_lo;
		logic [ADDR_W-1:0]   second_hi;
		logic [ADDR_W-1:0]   second_lo;
		logic [ADDR_W-1:0]   mask_hi;
		logic [ADDR_W-1:0]   mask_lo;
		logic [FLAGS_W-1:0]  flags;
		logic [PRIO_W-1:0]   prio;
		logic [INDEX_W-1:0]  rule_index;
	} item_t;

	// running result handed from cell to cell
	typedef struct packed {
		logic [PRIO_W-1:0] best;
		logic              drop;
		logic              pending;
	} carry_t;

endpackage

/* design/ipv6_masked_rule_firewall_unit.sv */
// ----------------------------------------------------------------------------
// ipv6_masked_rule_firewall_unit
// ipv6 address/mask packet filter built as a chain of rule-slot cells
// ----------------------------------------------------------------------------
// pipeline: each cell registers the item on its way from input accept to result valid
// throughput: one item per cycle; the whole chain holds while a result waits
// reset: arst_n clears every slot to empty and drops all items in flight
// ----------------------------------------------------------------------------
module ipv6_masked_rule_firewall_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// mode [1:0]
	input  logic [ipfw_pkg::IN_USER_W-1:0]    s_tuser,
	// first_addr_hi [63:0], first_addr_lo [127:64], second_addr_hi [191:128],
	// second_addr_lo [255:192], rule_mask_hi [319:256], rule_mask_lo [383:320],
	// match_source [384], match_destination [385], drop_on_match [386],
	// rule_priority [394:387], rule_index [402:395], zero fill [407:403]
	input  logic [ipfw_pkg::IN_DATA_W-1:0]    s_tdata,
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// blocked [0], status [1], zero fill [7:2]
	output logic [ipfw_pkg::OUT_DATA_W-1:0]   m_tdata
);

	// chain taps: index 0 is the input, index NUM_RULES is the last cell output
	logic             chain_valid [ipfw_pkg::NUM_RULES+1];
	ipfw_pkg::item_t  chain_item  [ipfw_pkg::NUM_RULES+1];
	ipfw_pkg::carry_t chain_carry [ipfw_pkg::NUM_RULES+1];

	logic             advance;
	ipfw_pkg::item_t  last_item;
	ipfw_pkg::carry_t last_carry;
	logic             blocked;
	logic             status;

	// the last cell register is the output register; hold everything on a stall
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	// unpack the incoming item
	always_comb begin
		chain_item[0].mode       = ipfw_pkg::mode_t'(s_tuser[1:0]);
		chain_item[0].first_hi   = s_tdata[63:0];
		chain_item[0].first_lo   = s_tdata[127:64];
		chain_item[0].second_hi  = s_tdata[191:128];
		chain_item[0].second_lo  = s_tdata[255:192];
		chain_item[0].mask_hi    = s_tdata[319:256];
		chain_item[0].mask_lo    = s_tdata[383:320];
		chain_item[0].flags      = s_tdata[386:384];
		chain_item[0].prio       = s_tdata[394:387];
		chain_item[0].rule_index = s_tdata[402:395];
	end

	// lookup starts at priority zero with a drop verdict; add starts unplaced
	always_comb begin
		chain_valid[0]         = s_tvalid;
		chain_carry[0].best    = '0;
		chain_carry[0].drop    = 1'b1;
		chain_carry[0].pending = (chain_item[0].mode == ipfw_pkg::MODE_ADD);
	end

	// one cell per rule slot, visited in slot order
	for (genvar g = 0; g < ipfw_pkg::NUM_RULES; g++) begin : g_cell
		ipfw_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.slot_id   (ipfw_pkg::INDEX_W'(g)),
			.in_valid  (chain_valid[g]),
			.in_item   (chain_item[g]),
			.in_carry  (chain_carry[g]),
			.out_valid (chain_valid[g+1]),
			.out_item  (chain_item[g+1]),
			.out_carry (chain_carry[g+1])
		);
	end

	assign last_item  = chain_item[ipfw_pkg::NUM_RULES];
	assign last_carry = chain_carry[ipfw_pkg::NUM_RULES];

	// verdict only for lookups, full-table status only for adds left unplaced
	assign blocked = (last_item.mode == ipfw_pkg::MODE_LOOKUP) && last_carry.drop;
	assign status  = (last_item.mode == ipfw_pkg::MODE_ADD) && last_carry.pending;

	assign m_tvalid = chain_valid[ipfw_pkg::NUM_RULES];
	assign m_tdata  = {{(ipfw_pkg::OUT_DATA_W-2){1'b0}}, status, blocked};

	// a result never reports both a drop verdict and a failed add
	a_verdict_status_excl : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("blocked and status both set");

	// a waiting result must hold off new input
	a_stall_blocks_input : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while result stalled");

	// an accepted item lands in the first cell
	a_accept_enters_chain : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> chain_valid[1])
		else $error("accepted item lost at chain entry");

	// a stalled chain keeps its output result
	a_stall_holds_result : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed during stall");

endmodule

/* design/ipfw_cell.sv */
// ----------------------------------------------------------------------------
// ipfw_cell
// one rule slot: holds a rule, applies the passing request, hands it on
// ----------------------------------------------------------------------------
module ipfw_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [ipfw_pkg::INDEX_W-1:0]  slot_id,
	input  logic                          in_valid,
	input  ipfw_pkg::item_t               in_item,
	input  ipfw_pkg::carry_t              in_carry,
	output logic                          out_valid,
	output ipfw_pkg::item_t               out_item,
	output ipfw_pkg::carry_t              out_carry
);

	logic [ipfw_pkg::ADDR_W-1:0]  addr_hi_q;
	logic [ipfw_pkg::ADDR_W-1:0]  addr_lo_q;
	logic [ipfw_pkg::ADDR_W-1:0]  mask_hi_q;
	logic [ipfw_pkg::ADDR_W-1:0]  mask_lo_q;
	logic [ipfw_pkg::PRIO_W-1:0]  prio_q;
	logic [ipfw_pkg::FLAGS_W-1:0] flags_q;

	logic             valid_s1;
	ipfw_pkg::item_t  item_s1;
	ipfw_pkg::carry_t carry_s1;

	logic             occupied;
	logic             src_hit;
	logic             dst_hit;
	logic             write_rule;
	logic             clear_rule;
	logic             step;
	ipfw_pkg::carry_t carry_nxt;

	assign occupied = (flags_q != '0);
	assign step     = en && in_valid;

	assign src_hit = flags_q[ipfw_pkg::FLG_SRC_BIT]
		&& (((in_item.first_hi ^ addr_hi_q) & mask_hi_q) == '0)
		&& (((in_item.first_lo ^ addr_lo_q) & mask_lo_q) == '0);
	assign dst_hit = flags_q[ipfw_pkg::FLG_DST_BIT]
		&& (((in_item.second_hi ^ addr_hi_q) & mask_hi_q) == '0)
		&& (((in_item.second_lo ^ addr_lo_q) & mask_lo_q) == '0);

	always_comb begin
		carry_nxt  = in_carry;
		write_rule = 1'b0;
		clear_rule = 1'b0;
		case (in_item.mode)
			ipfw_pkg::MODE_LOOKUP: begin
				if (occupied && (in_carry.best <= prio_q) && (src_hit || dst_hit)) begin
					carry_nxt.drop = flags_q[ipfw_pkg::FLG_DROP_BIT];
					carry_nxt.best = prio_q;
				end
			end
			ipfw_pkg::MODE_ADD: begin
				// first empty slot down the chain takes the rule
				if (in_carry.pending && !occupied) begin
					write_rule        = 1'b1;
					carry_nxt.pending = 1'b0;
				end
			end
			ipfw_pkg::MODE_DEL_ADDR: begin
				clear_rule = occupied && (addr_hi_q == in_item.first_hi)
					&& (addr_lo_q == in_item.first_lo);
			end
			ipfw_pkg::MODE_DEL_IDX: begin
				clear_rule = (in_item.rule_index == slot_id);
			end
			default: begin
				clear_rule = 1'b0;
			end
		endcase
	end

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (step) begin
			if (write_rule) begin
				flags_q <= in_item.flags;
			end else if (clear_rule) begin
				flags_q <= '0;
			end
		end
	end

	// rule contents, meaningful only while occupied
	always_ff @(posedge clk) begin
		if (step && write_rule) begin
			addr_hi_q <= in_item.first_hi;
			addr_lo_q <= in_item.first_lo;
			mask_hi_q <= in_item.mask_hi;
			mask_lo_q <= in_item.mask_lo;
			prio_q    <= in_item.prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1  <= in_item;
			carry_s1 <= carry_nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;
	assign out_carry = carry_s1;

endmodule

/* tb/fw_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// fw_tb_pkg
// request type and verdict scoreboard for the ipv6 firewall testbench
// ----------------------------------------------------------------------------
package fw_tb_pkg;

	import ipfw_pkg::*;

	// one request as the testbench sees it, fields in the order of the stream
	typedef struct packed {
		mode_t        mode;
		logic [63:0]  first_hi;
		logic [63:0]  first_lo;
		logic [63:0]  second_hi;
		logic [63:0]  second_lo;
		logic [63:0]  mask_hi;
		logic [63:0]  mask_lo;
		logic         match_src;
		logic         match_dst;
		logic         drop;
		logic [7:0]   prio;
		logic [7:0]   index;
	} fw_request_t;

	typedef struct packed {
		logic blocked;
		logic status;
	} fw_verdict_t;

	class fw_scoreboard;
		// shadow rule table
		bit [63:0] rule_addr_hi[NUM_RULES];
		bit [63:0] rule_addr_lo[NUM_RULES];
		bit [63:0] rule_mask_hi[NUM_RULES];
		bit [63:0] rule_mask_lo[NUM_RULES];
		bit [2:0]  rule_flags[NUM_RULES];
		bit [7:0]  rule_prio[NUM_RULES];

		fw_verdict_t verdicts_due[$];
		int          errors;
		int          results_seen;

		function new();
			errors = 0;
			results_seen = 0;
			foreach (rule_flags[s]) begin
				rule_addr_hi[s] = '0;
				rule_addr_lo[s] = '0;
				rule_mask_hi[s] = '0;
				rule_mask_lo[s] = '0;
				rule_flags[s]   = '0;
				rule_prio[s]    = '0;
			end
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", what);
		endfunction

		function bit slot_hit(int s, bit [63:0] hi, bit [63:0] lo);
			return ((hi ^ rule_addr_hi[s]) & rule_mask_hi[s]) == '0 &&
			       ((lo ^ rule_addr_lo[s]) & rule_mask_lo[s]) == '0;
		endfunction

		// work out the verdict of an accepted request and update the table
		function void note_request(fw_request_t r);
			fw_verdict_t v;
			bit [7:0]    best;
			bit [2:0]    f;
			v.blocked = 1'b0;
			v.status  = 1'b0;
			case (r.mode)
				MODE_LOOKUP: begin
					best = '0;
					v.blocked = 1'b1;
					for (int s = 0; s < NUM_RULES; s++) begin
						f = rule_flags[s];
						if (f == '0 || best > rule_prio[s])
							continue;
						if (f[FLG_SRC_BIT] && slot_hit(s, r.first_hi, r.first_lo)) begin
							v.blocked = f[FLG_DROP_BIT];
							best = rule_prio[s];
						end
						if (f[FLG_DST_BIT] && slot_hit(s, r.second_hi, r.second_lo)) begin
							v.blocked = f[FLG_DROP_BIT];
							best = rule_prio[s];
						end
					end
				end
				MODE_ADD: begin
					v.status = 1'b1;
					for (int s = 0; s < NUM_RULES; s++) begin
						if (rule_flags[s] == '0) begin
							rule_addr_hi[s] = r.first_hi;
							rule_addr_lo[s] = r.first_lo;
							rule_mask_hi[s] = r.mask_hi;
							rule_mask_lo[s] = r.mask_lo;
							rule_flags[s]   = {r.drop, r.match_dst, r.match_src};
							rule_prio[s]    = r.prio;
							v.status = 1'b0;
							break;
						end
					end
				end
				MODE_DEL_ADDR: begin
					for (int s = 0; s < NUM_RULES; s++)
						if (rule_flags[s] != '0 && rule_addr_hi[s] == r.first_hi &&
						    rule_addr_lo[s] == r.first_lo)
							rule_flags[s] = '0;
				end
				default: begin
					if (r.index < NUM_RULES)
						rule_flags[r.index] = '0;
				end
			endcase
			verdicts_due.push_back(v);
		endfunction

		// compare one result item against the oldest verdict waiting
		function void check_result(logic [7:0] d);
			fw_verdict_t want;
			results_seen++;
			if (verdicts_due.size() == 0) begin
				flag($sformatf("result %0d (tdata %h) with no item waiting", results_seen, d));
				return;
			end
			want = verdicts_due.pop_front();
			if (d[0] !== want.blocked)
				flag($sformatf("result %0d blocked expected %0b got %b",
				               results_seen, want.blocked, d[0]));
			if (d[1] !== want.status)
				flag($sformatf("result %0d status expected %0b got %b",
				               results_seen, want.status, d[1]));
			if (d[7:2] !== 6'b0)
				flag($sformatf("result %0d fill expected 0 got %b", results_seen, d[7:2]));
		endfunction
	endclass

endpackage

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives lookups, rule adds and both deletes into the firewall unit with
// random gaps and stalls, and checks each verdict against a shadow table
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import ipfw_pkg::*;
	import fw_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1325;
	localparam int QUIET_ITEMS  = 330;   // last stretch without any idling
	localparam int HOLD_AT      = 300;   // random item at which the long hold starts
	localparam int LONG_HOLD    = 64;    // cycles, well past the chain depth
	localparam int DRAIN_LIMIT  = 20000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_USER_W-1:0]  s_tuser;    // mode [1:0]
	logic [IN_DATA_W-1:0]  s_tdata;    // first hi, first lo, second hi, second lo,
	                                   // mask hi, mask lo, src, dst, drop, prio, index
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;    // blocked, status, zero fill

	// request currently on the input bus, kept beside the packed tdata
	fw_request_t   bus_req;
	fw_scoreboard  sb = new();

	// idling controls, set by the stimulus process
	bit src_gaps;
	bit sink_stalls;
	bit hold_req;

	bit [127:0] addr_pool[4];

	ipv6_masked_rule_firewall_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop in case the handshake hangs
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// both handshakes are sampled at the edge, before any of this edge's updates
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_tvalid && s_tready)
				sb.note_request(bus_req);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// ------------------------------------------------------------------------
	// result side: random stall bursts, one long hold on request
	// ------------------------------------------------------------------------
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				// long hold stalls the whole chain once a result waits, so the input side stalls too
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// random 64-bit value with the extremes mixed in
	function automatic bit [63:0] rand64();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// prefix masks most often, plus all-ones, all-zero and scattered bits
	function automatic bit [127:0] rand_mask();
		bit [127:0] m;
		case ($urandom_range(0, 4))
			0:       m = '1;
			1:       m = '0;
			2:       m = {$urandom, $urandom, $urandom, $urandom};
			default: m = {128{1'b1}} << (128 - $urandom_range(0, 128));
		endcase
		return m;
	endfunction

	// every field random, so unused fields toggle too
	function automatic fw_request_t noise_req(mode_t m);
		fw_request_t r;
		r.mode      = m;
		r.first_hi  = rand64();
		r.first_lo  = rand64();
		r.second_hi = rand64();
		r.second_lo = rand64();
		r.mask_hi   = rand64();
		r.mask_lo   = rand64();
		r.match_src = 1'($urandom_range(0, 1));
		r.match_dst = 1'($urandom_range(0, 1));
		r.drop      = 1'($urandom_range(0, 1));
		r.prio      = 8'($urandom_range(0, 255));
		r.index     = 8'($urandom_range(0, 255));
		return r;
	endfunction

	function automatic int pick_live_slot();
		int live[$];
		for (int s = 0; s < NUM_RULES; s++)
			if (sb.rule_flags[s] != '0)
				live.push_back(s);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	// address that mostly falls inside a live rule, sometimes one bit off
	function automatic bit [127:0] aimed_addr();
		int         s;
		bit [127:0] a;
		bit [127:0] m;
		bit [127:0] noise;
		s = pick_live_slot();
		noise = {rand64(), rand64()};
		if (s < 0 || $urandom_range(0, 9) < 3)
			return noise;
		a = {sb.rule_addr_hi[s], sb.rule_addr_lo[s]};
		m = {sb.rule_mask_hi[s], sb.rule_mask_lo[s]};
		a = (a & m) | (noise & ~m);
		if ($urandom_range(0, 7) == 0)
			a = a ^ (128'b1 << $urandom_range(0, 127));
		return a;
	endfunction

	// offer one item and hold it until the block takes it
	task automatic send_request(fw_request_t r);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		bus_req  <= r;
		s_tuser  <= r.mode;
		s_tdata  <= {5'b0, r.index, r.prio, r.drop, r.match_dst, r.match_src,
		             r.mask_lo, r.mask_hi, r.second_lo, r.second_hi,
		             r.first_lo, r.first_hi};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic add_rule(bit [127:0] addr, bit [127:0] mask, bit [2:0] flags,
	                        bit [7:0] prio);
		fw_request_t r;
		r = noise_req(MODE_ADD);
		{r.first_hi, r.first_lo} = addr;
		{r.mask_hi, r.mask_lo}   = mask;
		{r.drop, r.match_dst, r.match_src} = flags;
		r.prio = prio;
		send_request(r);
	endtask

	task automatic lookup(bit [127:0] src, bit [127:0] dst);
		fw_request_t r;
		r = noise_req(MODE_LOOKUP);
		{r.first_hi, r.first_lo}   = src;
		{r.second_hi, r.second_lo} = dst;
		send_request(r);
	endtask

	task automatic del_index(bit [7:0] idx);
		fw_request_t r;
		r = noise_req(MODE_DEL_IDX);
		r.index = idx;
		send_request(r);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		fw_request_t r;
		int          s;
		int          w;
		int          waited;
		bit [127:0]  addr_a;
		bit [127:0]  addr_b;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= '0;
		s_tdata  <= '0;
		bus_req  <= '0;
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		hold_req    = 1'b0;
		foreach (addr_pool[i])
			addr_pool[i] = {$urandom, $urandom, $urandom, $urandom};
		addr_a = 128'h2001_0db8_0000_0001_0000_0000_0000_0001;
		addr_b = 128'hfe80_0000_0000_0000_0211_22ff_fe33_4455;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: table is empty after reset
		lookup('1, '0);                       // no rule at all, default drop
		del_index(8'd0);                      // clearing an empty slot
		add_rule(addr_a, '1, 3'b001, 8'd0);   // source rule, pass
		lookup(addr_a, '0);
		add_rule(addr_a, '1, 3'b110, 8'd0);   // same priority later, dest, drop
		lookup(addr_a, addr_a);               // both rules hit, later one wins
		add_rule(addr_b, '0, 3'b011, 8'd255); // zero mask matches anything
		lookup({rand64(), rand64()}, {rand64(), rand64()});
		add_rule(addr_b, '1, 3'b100, 8'd255); // drop flag only, never matches
		add_rule(addr_a, '1, 3'b000, 8'd255); // no flags, slot stays empty
		add_rule('1, {{64{1'b1}}, 64'b0}, 3'b101, 8'd255);
		lookup({64'hffff_ffff_ffff_ffff, rand64()}, '0);
		add_rule('0, '0, 3'b101, 8'd1);       // low priority, skipped after 255
		add_rule(addr_a, '1, 3'b010, 8'd0);
		add_rule(addr_b, {128{1'b1}} << 64, 3'b001, 8'd255);
		add_rule(addr_a, '1, 3'b111, 8'd255); // table full
		lookup('0, '0);
		r = noise_req(MODE_DEL_ADDR);         // clears all three rules at addr_b
		{r.first_hi, r.first_lo} = addr_b;
		send_request(r);
		lookup(addr_b, addr_b);
		del_index(8'(NUM_RULES - 1));
		del_index(8'(NUM_RULES));             // just out of range
		del_index(8'd255);
		add_rule(addr_b, '1, 3'b111, 8'd0);   // lands in the first freed slot
		lookup(addr_b, '1);

		// random part
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_req = 1'b1;
			if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
				src_gaps    = 1'b0;
				sink_stalls = 1'b0;
			end
			w = $urandom_range(0, 99);
			if (w < 45) begin
				r = noise_req(MODE_LOOKUP);
				{r.first_hi, r.first_lo}   = aimed_addr();
				{r.second_hi, r.second_lo} = aimed_addr();
			end else if (w < 75) begin
				r = noise_req(MODE_ADD);
				if ($urandom_range(0, 9) < 4)
					{r.first_hi, r.first_lo} = addr_pool[$urandom_range(0, 3)];
				{r.mask_hi, r.mask_lo} = rand_mask();
				// crowd the priorities so ties and overrides happen often
				case ($urandom_range(0, 3))
					0:       r.prio = '0;
					1:       r.prio = '1;
					2:       r.prio = 8'($urandom_range(0, 3));
					default: ;
				endcase
			end else if (w < 85) begin
				r = noise_req(MODE_DEL_ADDR);
				s = pick_live_slot();
				w = $urandom_range(0, 9);
				if (s >= 0 && w < 6)
					{r.first_hi, r.first_lo} = {sb.rule_addr_hi[s], sb.rule_addr_lo[s]};
				else if (w < 8)
					{r.first_hi, r.first_lo} = addr_pool[$urandom_range(0, 3)];
			end else begin
				r = noise_req(MODE_DEL_IDX);
				if ($urandom_range(0, 4) != 0)
					r.index = 8'($urandom_range(0, NUM_RULES - 1));
			end
			send_request(r);
		end
		s_tvalid <= 1'b0;

		// drain, then wait on to catch stray results
		waited = 0;
		while (sb.verdicts_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * NUM_RULES + 8) @(posedge clk);
		if (sb.verdicts_due.size() != 0)
			sb.flag($sformatf("%0d results never arrived", sb.verdicts_due.size()));

		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
